@@ src/bss_pkg.sv @@
// Shared types, codes and sizes for the shift-or substring search block.
package bss_pkg;

    // Field widths fixed by the item formats
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned SYM_W   = 7;
    localparam int unsigned CFG_W   = 6;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned POS_W   = 16;

    // Table and search sizes
    localparam int unsigned ALPHABET_SIZE    = 2 ** SYM_W;
    localparam int unsigned MAX_PATTERN_DEF  = 63;
    localparam int unsigned VEC_W            = 2 ** CFG_W;
    localparam int unsigned QUEUE_DEPTH      = 2;

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

    // Status codes on the result channel
    localparam logic [STAT_W-1:0] ST_SEARCHING = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MATCH  = 2'd2;

    // Operations passed from the front end to the execution side
    typedef enum logic [1:0] {
        OP_START,
        OP_LOAD,
        OP_TEXT
    } op_t;

    // One queued operation
    typedef struct packed {
        op_t              op;
        logic [SYM_W-1:0] sym;
        logic [CFG_W-1:0] bit_idx;
        logic             last;
    } entry_t;

endpackage

@@ src/bss_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface bss_req_if;
    logic                         valid;
    logic                         ready;
    logic [bss_pkg::REQ_W-1:0]    req_type;
    logic [bss_pkg::SYM_W-1:0]    symbol;
    logic                         last_text;

    modport source (output valid, output req_type, output symbol, output last_text,
                    input ready);
    modport sink (input valid, input req_type, input symbol, input last_text,
                  output ready);
endinterface

interface bss_resp_if;
    logic                         valid;
    logic                         ready;
    logic [bss_pkg::STAT_W-1:0]   status;
    logic [bss_pkg::POS_W-1:0]    match_start;

    modport source (output valid, output status, output match_start, input ready);
    modport sink (input valid, input status, input match_start, output ready);
endinterface

@@ src/bss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bss_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port: old data on a same-address collision, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bss_queue.sv @@
// Short operation queue between the front end and the execution side.
module bss_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bss_pkg::entry_t  push_item,
    output logic             push_ready,
    output logic             pop_valid,
    output bss_pkg::entry_t  pop_item,
    input  logic             pop
);

    localparam int unsigned DEPTH = bss_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bss_pkg::entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign push_ready = (count_reg < CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/bss_front.sv @@
// Front end: accepts request beats, tracks pattern loading and queues operations.
module bss_front #(
    parameter int unsigned MAX_PATTERN = bss_pkg::MAX_PATTERN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bss_req_if.sink                    req,
    input  logic [bss_pkg::CFG_W-1:0]  pattern_length,
    output logic                       push,
    output bss_pkg::entry_t            push_item,
    input  logic                       push_ready
);

    logic [bss_pkg::CFG_W-1:0] loaded_reg;
    logic [bss_pkg::CFG_W-1:0] loaded_next;
    logic                      accept;
    logic                      load_ok;
    logic                      keep;

    assign req.ready = push_ready;
    assign accept    = req.valid && push_ready;

    // A load counts only while the pattern is still short of its length
    assign load_ok = (loaded_reg < pattern_length) &&
                     (loaded_reg < bss_pkg::CFG_W'(MAX_PATTERN));

    // Classify the beat
    always_comb
    begin
        keep              = 1'b0;
        loaded_next       = loaded_reg;
        push_item.op      = bss_pkg::OP_TEXT;
        push_item.sym     = req.symbol;
        push_item.bit_idx = loaded_reg;
        push_item.last    = req.last_text;
        unique case (req.req_type)
            bss_pkg::REQ_START:
            begin
                keep         = 1'b1;
                push_item.op = bss_pkg::OP_START;
                loaded_next  = '0;
            end
            bss_pkg::REQ_PATTERN:
            begin
                keep         = load_ok;
                push_item.op = bss_pkg::OP_LOAD;
                if (load_ok)
                begin
                    loaded_next = loaded_reg + 1'b1;
                end
            end
            bss_pkg::REQ_TEXT:
            begin
                keep         = 1'b1;
                push_item.op = bss_pkg::OP_TEXT;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

    // Track how many pattern symbols have been loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
        end
        else if (accept)
        begin
            loaded_reg <= loaded_next;
        end
    end

endmodule

@@ src/bss_back.sv @@
// Execution side: mask table, shift-or search state and the result register.
module bss_back #(
    parameter int unsigned MAX_PATTERN = bss_pkg::MAX_PATTERN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  bss_pkg::entry_t            q_item,
    output logic                       pop,
    input  logic [bss_pkg::CFG_W-1:0]  pattern_length,
    bss_resp_if.source                 resp
);

    localparam int unsigned MW    = MAX_PATTERN + 1;
    localparam int unsigned DEPTH = bss_pkg::ALPHABET_SIZE;
    localparam int unsigned POS_W = bss_pkg::POS_W;

    // Execute stage
    logic                   ex_valid_reg;
    bss_pkg::entry_t        ex_item_reg;
    logic                   ex_fire;
    logic                   byp_hit_reg;
    logic [MW-1:0]          byp_data_reg;

    // Search state
    logic [DEPTH-1:0]       mask_valid_reg;
    logic [MW-1:0]          vec_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   found_reg;
    logic [POS_W-1:0]       found_start_reg;

    // Result register
    logic                          out_valid_reg;
    logic [bss_pkg::STAT_W-1:0]    out_status_reg;
    logic [POS_W-1:0]              out_start_reg;

    logic [MW-1:0]              ram_rdata;
    logic                       ram_we;
    logic [MW-1:0]              mask_cur;
    logic [MW-1:0]              mask_new;
    logic [MW-1:0]              shifted;
    logic [bss_pkg::VEC_W-1:0]  shifted_ext;
    logic                       len_zero;
    logic                       len_ok;
    logic                       hit;
    logic                       text_found;
    logic [POS_W-1:0]           start_calc;
    logic [POS_W-1:0]           res_start;
    logic [bss_pkg::STAT_W-1:0] res_status;
    logic                       is_text;

    assign is_text = (ex_item_reg.op == bss_pkg::OP_TEXT);
    assign ex_fire = ex_valid_reg && (!is_text || !out_valid_reg || resp.ready);
    assign pop     = q_valid && (!ex_valid_reg || ex_fire);
    assign ram_we  = ex_fire && (ex_item_reg.op == bss_pkg::OP_LOAD);

    bss_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ex_item_reg.sym),
        .wdata (mask_new),
        .re    (pop),
        .raddr (q_item.sym),
        .rdata (ram_rdata)
    );

    // Current mask: forwarded write, stored entry, or all ones when unwritten
    always_comb
    begin
        if (!mask_valid_reg[ex_item_reg.sym])
        begin
            mask_cur = '1;
        end
        else if (byp_hit_reg)
        begin
            mask_cur = byp_data_reg;
        end
        else
        begin
            mask_cur = ram_rdata;
        end
    end

    assign mask_new = mask_cur & ~(MW'(1) << ex_item_reg.bit_idx);

    // Shift-or step and match test
    assign shifted     = (vec_reg | mask_cur) << 1;
    assign shifted_ext = bss_pkg::VEC_W'(shifted);
    assign len_zero    = (pattern_length == '0);
    assign len_ok      = (pattern_length <= bss_pkg::CFG_W'(MAX_PATTERN));
    assign hit         = !len_zero && len_ok && !shifted_ext[pattern_length];
    assign start_calc  = pos_reg + POS_W'(1) - POS_W'(pattern_length);
    assign text_found  = found_reg || len_zero || hit;

    always_comb
    begin
        if (found_reg)
        begin
            res_start = found_start_reg;
        end
        else if (len_zero)
        begin
            res_start = '0;
        end
        else if (hit)
        begin
            res_start = start_calc;
        end
        else
        begin
            res_start = '0;
        end
    end

    assign res_status = text_found ? bss_pkg::ST_FOUND :
                        (ex_item_reg.last ? bss_pkg::ST_NO_MATCH : bss_pkg::ST_SEARCHING);

    // Move the queue head into the execute stage and note any collision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                ex_valid_reg <= 1'b1;
                byp_hit_reg  <= ram_we && (ex_item_reg.sym == q_item.sym);
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end
        end
    end

    // Execute stage payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ex_item_reg  <= q_item;
            byp_data_reg <= mask_new;
        end
    end

    // Update the search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_valid_reg  <= '0;
            vec_reg         <= ~MW'(1);
            pos_reg         <= '0;
            found_reg       <= 1'b0;
            found_start_reg <= '0;
        end
        else if (ex_fire)
        begin
            case (ex_item_reg.op)
                bss_pkg::OP_START:
                begin
                    mask_valid_reg  <= '0;
                    vec_reg         <= ~MW'(1);
                    pos_reg         <= '0;
                    found_reg       <= 1'b0;
                    found_start_reg <= '0;
                end
                bss_pkg::OP_LOAD:
                begin
                    mask_valid_reg[ex_item_reg.sym] <= 1'b1;
                end
                bss_pkg::OP_TEXT:
                begin
                    if (!found_reg)
                    begin
                        if (len_zero)
                        begin
                            found_reg       <= 1'b1;
                            found_start_reg <= '0;
                        end
                        else
                        begin
                            vec_reg <= shifted;
                            pos_reg <= pos_reg + 1'b1;
                            if (hit)
                            begin
                                found_reg       <= 1'b1;
                                found_start_reg <= start_calc;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register: fill on a text beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ex_fire && is_text)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (resp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire && is_text)
        begin
            out_status_reg <= res_status;
            out_start_reg  <= text_found ? res_start : '0;
        end
    end

    assign resp.valid       = out_valid_reg;
    assign resp.status      = out_status_reg;
    assign resp.match_start = out_start_reg;

endmodule

@@ src/bitap_substring_search.sv @@
// A text beat's result is valid after the queue, execute stage and result register.
// Throughput: one request beat per cycle when the queue has room, set by the single
// mask-table read per beat, with a forwarded write for a load then the same symbol.
// Start and pattern beats give no result; unused request codes are dropped.
// Reset clears the mask valid bits, search state, queue and pattern length at once.
// The mask table itself is never cleared; its valid bits stand for it.
module bitap_substring_search #(
    parameter int unsigned MAX_PATTERN = bss_pkg::MAX_PATTERN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bss_req_if.sink                    request,
    bss_resp_if.source                 result,
    input  logic                       cfg_wr_en,
    input  logic [bss_pkg::CFG_W-1:0]  cfg_wr_data
);

    logic [bss_pkg::CFG_W-1:0] pattern_length_reg;
    logic                      push;
    logic                      push_ready;
    bss_pkg::entry_t           push_item;
    logic                      q_valid;
    bss_pkg::entry_t           q_item;
    logic                      pop;

    // Pattern length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            pattern_length_reg <= cfg_wr_data;
        end
    end

    bss_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (request),
        .pattern_length (pattern_length_reg),
        .push           (push),
        .push_item      (push_item),
        .push_ready     (push_ready)
    );

    bss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop        (pop)
    );

    bss_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .pattern_length (pattern_length_reg),
        .resp           (result)
    );

endmodule
